/* rtl/als_pkg.sv */
// Package for the anonymous label store: field widths, operation and
// status codes, and the store command struct. No dependencies.
`timescale 1ns / 1ps

package als_pkg;

  localparam int ADDR_W   = 16;
  localparam int COUNT_W  = 8;
  localparam int DEPTH_DEF = 64;

  typedef enum logic [2:0] {
    OP_DEF_FWD    = 3'd0,
    OP_DEF_BACK   = 3'd1,
    OP_RES_FWD    = 3'd2,
    OP_RES_BACK   = 3'd3,
    OP_ADVANCE    = 3'd4,
    OP_RESET_PASS = 3'd5,
    OP_CLEAR      = 3'd6
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_MISSING = 2'd1,
    ST_FULL    = 2'd2
  } status_t;

  typedef struct packed {
    logic fwd_we;
    logic fwd_re;
    logic back_we;
    logic back_re;
  } store_cmd_t;

endpackage

/* rtl/als_if.sv */
// Valid/ready channel interfaces for the anonymous label store words.
// Depends on als_pkg.
`timescale 1ns / 1ps

interface als_in_if;
  logic                         valid;
  logic                         ready;
  als_pkg::op_t                 operation;
  logic [als_pkg::ADDR_W-1:0]   label_address;
  logic [als_pkg::COUNT_W-1:0]  ref_count;

  modport source (output valid, operation, label_address, ref_count, input ready);
  modport sink   (input valid, operation, label_address, ref_count, output ready);
endinterface

interface als_out_if;
  logic                         valid;
  logic                         ready;
  als_pkg::status_t             status;
  logic [als_pkg::ADDR_W-1:0]   resolved_address;

  modport source (output valid, status, resolved_address, input ready);
  modport sink   (input valid, status, resolved_address, output ready);
endinterface

/* rtl/als_store.sv */
// One label address store: single port RAM, one write, one registered read or
// both per cycle. Depends on als_pkg.
`timescale 1ns / 1ps

module als_store #(
  parameter int LABEL_DEPTH = als_pkg::DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              we,
  input  logic                              re,
  input  logic [$clog2(LABEL_DEPTH)-1:0]    idx,
  input  logic [als_pkg::ADDR_W-1:0]        wdata,
  output logic [als_pkg::ADDR_W-1:0]        rdata
);
  import als_pkg::*;

  logic [ADDR_W-1:0] mem [LABEL_DEPTH];
  logic [ADDR_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[idx] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[idx];
    end
  end

  assign rdata = rdata_r;

endmodule

/* rtl/als_ctrl.sv */
// Fill levels, cursor and operation decode for the label store.
// Depends on als_pkg.
`timescale 1ns / 1ps

module als_ctrl #(
  parameter int LABEL_DEPTH = als_pkg::DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              accept,
  input  als_pkg::op_t                      operation,
  input  logic [als_pkg::COUNT_W-1:0]       ref_count,
  output als_pkg::store_cmd_t               cmd,
  output logic [$clog2(LABEL_DEPTH)-1:0]    fwd_idx,
  output logic [$clog2(LABEL_DEPTH)-1:0]    back_idx,
  output als_pkg::status_t                  status
);
  import als_pkg::*;

  localparam int IW = $clog2(LABEL_DEPTH);
  localparam int CW = $clog2(LABEL_DEPTH + 1);
  localparam int MW = (CW > COUNT_W) ? CW : COUNT_W;
  localparam int TW = MW + 1;
  localparam logic [CW-1:0] DEPTH_C = CW'(LABEL_DEPTH);

  logic [CW-1:0] fwd_fill_r, fwd_fill_nxt;
  logic [CW-1:0] cursor_r, cursor_nxt;
  logic [CW-1:0] back_fill_r, back_fill_nxt;

  logic [TW-1:0] fwd_tgt;
  logic [MW-1:0] back_tgt;
  logic [MW-1:0] count_m;
  logic          count_zero;
  store_cmd_t    cmd_c;

  assign count_m    = MW'(ref_count);
  assign count_zero = (ref_count == '0);
  assign fwd_tgt    = TW'(cursor_r) + TW'(ref_count) - TW'(1);
  assign back_tgt   = MW'(back_fill_r) - count_m;

  always_comb begin
    fwd_fill_nxt  = fwd_fill_r;
    cursor_nxt    = cursor_r;
    back_fill_nxt = back_fill_r;
    cmd_c         = '0;
    status        = ST_OK;
    fwd_idx       = fwd_fill_r[IW-1:0];
    back_idx      = back_fill_r[IW-1:0];
    unique case (operation)
      OP_DEF_FWD: begin
        if (fwd_fill_r >= DEPTH_C) begin
          status = ST_FULL;
        end else begin
          cmd_c.fwd_we = 1'b1;
          fwd_fill_nxt = fwd_fill_r + CW'(1);
        end
      end
      OP_DEF_BACK: begin
        if (back_fill_r >= DEPTH_C) begin
          status = ST_FULL;
        end else begin
          cmd_c.back_we = 1'b1;
          back_fill_nxt = back_fill_r + CW'(1);
        end
      end
      OP_RES_FWD: begin
        fwd_idx = fwd_tgt[IW-1:0];
        if (count_zero || fwd_tgt >= TW'(fwd_fill_r)) begin
          status = ST_MISSING;
        end else begin
          cmd_c.fwd_re = 1'b1;
        end
      end
      OP_RES_BACK: begin
        back_idx = back_tgt[IW-1:0];
        if (count_zero || count_m > MW'(back_fill_r)) begin
          status = ST_MISSING;
        end else begin
          cmd_c.back_re = 1'b1;
        end
      end
      OP_ADVANCE: begin
        if (cursor_r < fwd_fill_r) begin
          cursor_nxt = cursor_r + CW'(1);
        end
      end
      OP_RESET_PASS: begin
        cursor_nxt    = '0;
        back_fill_nxt = '0;
      end
      OP_CLEAR: begin
        fwd_fill_nxt  = '0;
        cursor_nxt    = '0;
        back_fill_nxt = '0;
      end
      default: begin
      end
    endcase
  end

  assign cmd = accept ? cmd_c : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_fill_r  <= '0;
      cursor_r    <= '0;
      back_fill_r <= '0;
    end else if (accept) begin
      fwd_fill_r  <= fwd_fill_nxt;
      cursor_r    <= cursor_nxt;
      back_fill_r <= back_fill_nxt;
    end
  end

  a_cursor_in_fill: assert property (@(posedge clk) disable iff (!rst_n)
    cursor_r <= fwd_fill_r)
    else $error("cursor beyond forward fill");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fwd_fill_r <= DEPTH_C && back_fill_r <= DEPTH_C)
    else $error("fill level beyond store depth");

  a_one_access: assert property (@(posedge clk) disable iff (!rst_n)
    $countones({cmd.fwd_we, cmd.fwd_re, cmd.back_we, cmd.back_re}) <= 1)
    else $error("more than one store access in a cycle");

  a_read_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.fwd_re || cmd.back_re) |-> status == ST_OK)
    else $error("store read on a failed resolve");

endmodule

/* rtl/anonymous_label_store.sv */
// Top level of the anonymous label store: channel handshake, result
// register and the two stores. Depends on als_pkg, als_if, als_ctrl, als_store.
`timescale 1ns / 1ps

// One word in, one result word out, one word per cycle sustained while the
// output takes results. Each operation is decoded against the fill levels and
// cursor in the cycle it is taken; a resolve reads its store at that edge
// into its read register, so the result appears in the next cycle. A result
// register parts the channels: the input is taken while a result waits,
// as long as that result leaves at the same edge. Stores hold LABEL_DEPTH
// entries each; a define into a full store is dropped with status full.
module anonymous_label_store #(
  parameter int LABEL_DEPTH = als_pkg::DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  als_in_if.sink     in_ch,
  als_out_if.source  out_ch
);
  import als_pkg::*;

  localparam int IW = $clog2(LABEL_DEPTH);

  logic                accept;
  store_cmd_t          cmd;
  logic [IW-1:0]       fwd_idx;
  logic [IW-1:0]       back_idx;
  status_t             status_c;
  logic [ADDR_W-1:0]   fwd_rdata;
  logic [ADDR_W-1:0]   back_rdata;

  logic                out_valid_r;
  status_t             status_r;
  logic                use_fwd_r;
  logic                use_back_r;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  als_ctrl #(.LABEL_DEPTH(LABEL_DEPTH)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .operation (in_ch.operation),
    .ref_count (in_ch.ref_count),
    .cmd       (cmd),
    .fwd_idx   (fwd_idx),
    .back_idx  (back_idx),
    .status    (status_c)
  );

  als_store #(.LABEL_DEPTH(LABEL_DEPTH)) u_fwd_store (
    .clk   (clk),
    .we    (cmd.fwd_we),
    .re    (cmd.fwd_re),
    .idx   (fwd_idx),
    .wdata (in_ch.label_address),
    .rdata (fwd_rdata)
  );

  als_store #(.LABEL_DEPTH(LABEL_DEPTH)) u_back_store (
    .clk   (clk),
    .we    (cmd.back_we),
    .re    (cmd.back_re),
    .idx   (back_idx),
    .wdata (in_ch.label_address),
    .rdata (back_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status_r   <= status_c;
      use_fwd_r  <= cmd.fwd_re;
      use_back_r <= cmd.back_re;
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.status           = status_r;
  assign out_ch.resolved_address = use_fwd_r  ? fwd_rdata  :
                                   use_back_r ? back_rdata : '0;

endmodule
